// ===== hw/rtl/ssf_pkg.sv =====
`timescale 1ns / 1ps
package ssf_pkg;

	// fixed field widths
	localparam int VALUE_BITS = 40;
	localparam int ROOT_W     = 20;
	localparam int EXP_W      = 6;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int OSEL_W     = 3;

	// default sizes handed to the top level
	localparam int     DEF_SPAN        = 65536;
	localparam longint DEF_SMALL_LIMIT = 1048576;
	localparam int     DEF_MAX_FACTORS = 11;

	// input commands
	localparam logic CMD_BUILD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEG_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_HIGH = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE  = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADSEG = 2'd2;

	// result sources
	localparam logic [OSEL_W-1:0] OS_ZERO = 3'd0;
	localparam logic [OSEL_W-1:0] OS_BAD  = 3'd1;
	localparam logic [OSEL_W-1:0] OS_ST1  = 3'd2;
	localparam logic [OSEL_W-1:0] OS_MAP  = 3'd3;
	localparam logic [OSEL_W-1:0] OS_WORD = 3'd4;
	localparam logic [OSEL_W-1:0] OS_BIG  = 3'd5;

	typedef struct packed {
		logic                  command;
		logic [VALUE_BITS-1:0] value;
	} ssf_in_t;

	typedef struct packed {
		logic [STAT_W-1:0]     status;
		logic                  is_prime;
		logic [VALUE_BITS-1:0] factor;
		logic [EXP_W-1:0]      exponent;
		logic                  last;
	} ssf_out_t;

	typedef struct packed {
		logic              load_in;
		logic              clr_built;
		logic              set_built;
		logic              sq_start;
		logic              sq_step;
		logic              clr_init;
		logic              clr_step;
		logic              init_start;
		logic              init_step;
		logic              p_init;
		logic              p_inc;
		logic              mul;
		logic              mark_step;
		logic              ldiv_start;
		logic              off_load;
		logic              seg_cap;
		logic              seg_skip;
		logic              rdiv_start;
		logic              div_take;
		logic              seg_wr;
		logic              fin_init;
		logic              fin_wr;
		logic              q_cap;
		logic              k_inc;
		logic              emit;
		logic [OSEL_W-1:0] out_sel;
	} ssf_cmd_t;

	typedef struct packed {
		logic seg_bad;
		logic sq_last;
		logic root_big;
		logic j_gt_m;
		logic i_ge_span;
		logic p_gt_m;
		logic map_bit;
		logic div_busy;
		logic rem_zero;
		logic res_zero;
		logic built;
		logic v_le1;
		logic v_in_seg;
		logic v_in_small;
		logic total_zero;
		logic n_zero;
		logic k_last;
		logic has_big;
		logic slot_free;
	} ssf_sts_t;

endpackage

// ===== hw/rtl/segmented_sieve_factorizer_top.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_ready  | in_data (command, value)
// out      | output    | out_valid / out_ready| out_data (status .. last)
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item at a time; each extra result of a query waits on a registered read
// of the factor store
// a build clears the map, loads the span, then per prime p <= m marks its multiples
// and runs the shared divider on each multiple in the segment; the divider dominates
// no clearing pass after reset; each build clears the map up to its own root
// a stalled out channel holds the controller in its emit state
module segmented_sieve_factorizer_top import ssf_pkg::*; #(
	parameter int     SPAN        = DEF_SPAN,
	parameter longint SMALL_LIMIT = DEF_SMALL_LIMIT,
	parameter int     MAX_FACTORS = DEF_MAX_FACTORS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ssf_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ssf_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [VALUE_BITS-1:0] cfg_data
);

	ssf_cmd_t cmd;
	ssf_sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencer
	ssf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (in_data.command),
		.sts        (sts),
		.in_ready   (in_ready),
		.cmd        (cmd)
	);

	// stores, arithmetic and result register
	ssf_dp #(
		.SPAN        (SPAN),
		.SMALL_LIMIT (SMALL_LIMIT),
		.MAX_FACTORS (MAX_FACTORS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// error results are always single
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.last)
		else $error("error result not marked last");

	// a prime answer is one factor of multiplicity one
	a_prime_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_prime |-> out_data.exponent == EXP_W'(1) && out_data.last)
		else $error("prime result malformed");

	// no factor without a multiplicity
	a_exp_factor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.exponent == '0 |-> out_data.factor == '0)
		else $error("factor reported with zero exponent");
`endif

endmodule

// ===== hw/rtl/ssf_div.sv =====
`timescale 1ns / 1ps
module ssf_div import ssf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [ROOT_W-1:0]     divisor,
	output logic                  busy,
	output logic [VALUE_BITS-1:0] quot,
	output logic [ROOT_W-1:0]     rem
);

	localparam int CNT_W = $clog2(VALUE_BITS);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ROOT_W-1:0]     rem_q;
	logic [ROOT_W-1:0]     div_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [ROOT_W:0]       sh;
	logic                  fits;

	// one restoring step a cycle
	assign sh   = {rem_q, quo_q[VALUE_BITS-1]};
	assign fits = sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(VALUE_BITS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? ROOT_W'(sh - {1'b0, div_q}) : ROOT_W'(sh);
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/ssf_dp.sv =====
`timescale 1ns / 1ps
module ssf_dp import ssf_pkg::*; #(
	parameter int     SPAN        = DEF_SPAN,
	parameter longint SMALL_LIMIT = DEF_SMALL_LIMIT,
	parameter int     MAX_FACTORS = DEF_MAX_FACTORS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssf_in_t               in_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [VALUE_BITS-1:0] cfg_data,
	input  logic                  out_ready,
	input  ssf_cmd_t              cmd,
	output ssf_sts_t              sts,
	output logic                  out_valid,
	output ssf_out_t              out_data
);

	localparam int VW     = VALUE_BITS;
	localparam int IW     = $clog2(SPAN);
	localparam int SPW    = $clog2(SPAN + 1);
	localparam int MAP_AW = $clog2(SMALL_LIMIT);
	localparam int CW     = $clog2(MAX_FACTORS + 1);
	localparam int SAW    = $clog2(SPAN * MAX_FACTORS);
	localparam int OFF_W  = ((IW > ROOT_W) ? IW : ROOT_W) + 2;
	localparam int JW     = 2 * ROOT_W + 1;
	localparam int WORD_W = ROOT_W + EXP_W;
	localparam int SQ_CW  = $clog2(ROOT_W);

	// configuration and mode
	logic [VW-1:0]     lo_q, hi_q, v_q;
	logic              built_q, cmd_q;
	logic [ROOT_W-1:0] top_q;

	// root extraction
	logic [VW-1:0]       sq_src_q;
	logic [ROOT_W+1:0]   sq_rem_q;
	logic [ROOT_W-1:0]   m_q;
	logic [SQ_CW-1:0]    sq_cnt_q;
	logic [ROOT_W+3:0]   sq_sh;
	logic [ROOT_W+3:0]   sq_trial;
	logic                sq_fits;
	logic [SPW-1:0]      span_q;
	logic [VW:0]         diff;

	// sieve walk
	logic [JW-1:0]     j_q;
	logic [ROOT_W:0]   p_q;
	logic [OFF_W-1:0]  i_q;
	logic [IW-1:0]     idx;
	logic [VW-1:0]     res_q;
	logic [CW-1:0]     cnt_q;
	logic [EXP_W-1:0]  e_q;

	// divider
	logic              div_start, div_busy;
	logic [VW-1:0]     div_quot;
	logic [ROOT_W-1:0] div_rem;

	// memories
	logic              map_mem [SMALL_LIMIT];
	logic [VW-1:0]     res_mem [SPAN];
	logic [CW-1:0]     cnt_mem [SPAN];
	logic [VW-1:0]     big_mem [SPAN];
	logic [WORD_W-1:0] fac_mem [SPAN * MAX_FACTORS];
	logic              map_rd_q;
	logic [VW-1:0]     res_rd_q, big_rd_q;
	logic [CW-1:0]     cnt_rd_q;
	logic [WORD_W-1:0] fac_rd_q;
	logic              map_we, map_wd;
	logic [MAP_AW-1:0] map_wa, map_ra;
	logic [IW-1:0]     cnt_ra;

	// query
	logic [VW-1:0]     qoff;
	logic [IW-1:0]     qidx;
	logic [CW-1:0]     n_q, total_q, k_q, n_d;
	logic [VW-1:0]     big_q;
	logic              pr_q;

	// result register
	logic              out_valid_q;
	ssf_out_t          out_q, out_d;

	assign idx  = i_q[IW-1:0];
	assign diff = {1'b0, hi_q} - {1'b0, lo_q};
	assign qoff = v_q - lo_q;
	assign qidx = qoff[IW-1:0];

	// configuration, built flag, latched input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q    <= VW'(1);
			hi_q    <= VW'(1);
			built_q <= 1'b0;
			top_q   <= '0;
			cmd_q   <= CMD_BUILD;
		end else begin
			if (cfg_valid) begin
				built_q <= 1'b0;
				if (cfg_index == REG_SEG_LOW)
					lo_q <= cfg_data;
				else
					hi_q <= cfg_data;
			end else if (cmd.clr_built) begin
				built_q <= 1'b0;
			end else if (cmd.set_built) begin
				built_q <= 1'b1;
				top_q   <= m_q;
			end
			if (cmd.load_in)
				cmd_q <= in_data.command;
		end
	end

	// digit-by-digit square root, two bits a step
	assign sq_sh    = {sq_rem_q, sq_src_q[VW-1:VW-2]};
	assign sq_trial = (ROOT_W + 4)'({m_q, 2'b01});
	assign sq_fits  = sq_sh >= sq_trial;

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			v_q <= in_data.value;
		if (cmd.sq_start) begin
			sq_src_q <= hi_q;
			sq_rem_q <= '0;
			m_q      <= '0;
			sq_cnt_q <= '0;
			span_q   <= SPW'(diff + (VW + 1)'(1));
		end else if (cmd.sq_step) begin
			sq_src_q <= {sq_src_q[VW-3:0], 2'b00};
			sq_rem_q <= sq_fits ? (ROOT_W + 2)'(sq_sh - sq_trial) : (ROOT_W + 2)'(sq_sh);
			m_q      <= {m_q[ROOT_W-2:0], sq_fits};
			sq_cnt_q <= sq_cnt_q + SQ_CW'(1);
		end
	end

	// sieve counters and current residue
	always_ff @(posedge clk) begin
		if (cmd.clr_init)
			j_q <= '0;
		else if (cmd.clr_step)
			j_q <= j_q + JW'(1);
		else if (cmd.mul)
			j_q <= JW'(p_q * p_q);
		else if (cmd.mark_step)
			j_q <= j_q + JW'(p_q);

		if (cmd.p_init)
			p_q <= (ROOT_W + 1)'(2);
		else if (cmd.p_inc)
			p_q <= p_q + (ROOT_W + 1)'(1);

		if (cmd.init_start || cmd.fin_init)
			i_q <= '0;
		else if (cmd.init_step || cmd.fin_wr)
			i_q <= i_q + OFF_W'(1);
		else if (cmd.off_load)
			i_q <= (div_rem == '0) ? '0 : OFF_W'(p_q - (ROOT_W + 1)'(div_rem));
		else if (cmd.seg_skip || cmd.seg_wr)
			i_q <= i_q + OFF_W'(p_q);

		if (cmd.seg_cap) begin
			res_q <= res_rd_q;
			cnt_q <= cnt_rd_q;
			e_q   <= '0;
		end else if (cmd.div_take) begin
			res_q <= div_quot;
			e_q   <= e_q + EXP_W'(1);
		end
	end

	assign div_start = cmd.ldiv_start | cmd.rdiv_start;

	ssf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cmd.ldiv_start ? lo_q : res_q),
		.divisor  (p_q[ROOT_W-1:0]),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// composite map
	assign map_we = cmd.clr_step | cmd.mark_step;
	assign map_wd = cmd.mark_step | (j_q < JW'(2));
	assign map_wa = MAP_AW'(j_q);
	assign map_ra = (cmd_q == CMD_QUERY) ? MAP_AW'(v_q) : MAP_AW'(p_q);

	always_ff @(posedge clk) begin
		if (map_we)
			map_mem[map_wa] <= map_wd;
		map_rd_q <= map_mem[map_ra];
	end

	// residues
	always_ff @(posedge clk) begin
		if (cmd.init_step)
			res_mem[idx] <= lo_q + VW'(i_q);
		else if (cmd.seg_wr)
			res_mem[idx] <= res_q;
		res_rd_q <= res_mem[idx];
	end

	// factor counts
	assign cnt_ra = (cmd_q == CMD_QUERY) ? qidx : idx;

	always_ff @(posedge clk) begin
		if (cmd.init_step)
			cnt_mem[idx] <= '0;
		else if (cmd.seg_wr && cnt_q < CW'(MAX_FACTORS))
			cnt_mem[idx] <= cnt_q + CW'(1);
		cnt_rd_q <= cnt_mem[cnt_ra];
	end

	// prime and exponent words
	always_ff @(posedge clk) begin
		if (cmd.seg_wr && cnt_q < CW'(MAX_FACTORS))
			fac_mem[SAW'(idx) * SAW'(MAX_FACTORS) + SAW'(cnt_q)] <= {p_q[ROOT_W-1:0], e_q};
		fac_rd_q <= fac_mem[SAW'(qidx) * SAW'(MAX_FACTORS) + SAW'(k_q)];
	end

	// large cofactors
	always_ff @(posedge clk) begin
		if (cmd.fin_wr)
			big_mem[idx] <= (res_rd_q > VW'(1)) ? res_rd_q : '0;
		big_rd_q <= big_mem[qidx];
	end

	// query summary
	assign n_d = (cnt_rd_q > CW'(MAX_FACTORS)) ? CW'(MAX_FACTORS) : cnt_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			k_q <= '0;
		else if (cmd.k_inc)
			k_q <= k_q + CW'(1);
		if (cmd.q_cap) begin
			n_q     <= n_d;
			big_q   <= big_rd_q;
			total_q <= n_d + CW'((big_rd_q != '0) && (n_d < CW'(MAX_FACTORS)));
			if ((n_d + CW'((big_rd_q != '0) && (n_d < CW'(MAX_FACTORS)))) == CW'(1))
				pr_q <= (n_d == CW'(1)) ? (fac_rd_q[EXP_W-1:0] == EXP_W'(1)) : 1'b1;
			else
				pr_q <= 1'b0;
		end
	end

	// result selection
	always_comb begin
		out_d      = '0;
		out_d.last = 1'b1;
		unique case (cmd.out_sel)
			OS_ZERO: ;
			OS_BAD: out_d.status = ST_BADSEG;
			OS_ST1: out_d.status = ST_RANGE;
			OS_MAP: begin
				if (!map_rd_q) begin
					out_d.is_prime = 1'b1;
					out_d.factor   = v_q;
					out_d.exponent = EXP_W'(1);
				end
			end
			OS_WORD: begin
				out_d.is_prime = pr_q;
				out_d.factor   = VW'(fac_rd_q[WORD_W-1:EXP_W]);
				out_d.exponent = fac_rd_q[EXP_W-1:0];
				out_d.last     = (k_q == total_q - CW'(1));
			end
			OS_BIG: begin
				out_d.is_prime = pr_q;
				out_d.factor   = big_q;
				out_d.exponent = EXP_W'(1);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_q <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status back to the controller
	always_comb begin
		sts            = '0;
		sts.seg_bad    = (hi_q == '0) || (lo_q > hi_q) || (diff > (VW + 1)'(SPAN - 1));
		sts.sq_last    = sq_cnt_q == SQ_CW'(ROOT_W - 1);
		sts.root_big   = 64'(m_q) >= 64'(SMALL_LIMIT);
		sts.j_gt_m     = j_q > JW'(m_q);
		sts.i_ge_span  = i_q >= OFF_W'(span_q);
		sts.p_gt_m     = p_q > {1'b0, m_q};
		sts.map_bit    = map_rd_q;
		sts.div_busy   = div_busy;
		sts.rem_zero   = div_rem == '0;
		sts.res_zero   = res_q == '0;
		sts.built      = built_q;
		sts.v_le1      = v_q <= VW'(1);
		sts.v_in_seg   = (v_q >= lo_q) && (v_q <= hi_q) && (qoff < VW'(SPAN));
		sts.v_in_small = (64'(v_q) <= 64'(top_q)) && (64'(v_q) < 64'(SMALL_LIMIT));
		sts.total_zero = total_q == '0;
		sts.n_zero     = n_q == '0;
		sts.k_last     = k_q == n_q - CW'(1);
		sts.has_big    = total_q > n_q;
		sts.slot_free  = !out_valid_q || out_ready;
	end

endmodule

// ===== hw/rtl/ssf_ctrl.sv =====
`timescale 1ns / 1ps
module ssf_ctrl import ssf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_command,
	input  ssf_sts_t sts,
	output logic     in_ready,
	output ssf_cmd_t cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_OUT    = 5'd1;
	localparam logic [4:0] S_BCHK   = 5'd2;
	localparam logic [4:0] S_BSQ    = 5'd3;
	localparam logic [4:0] S_BSQCHK = 5'd4;
	localparam logic [4:0] S_BCLR   = 5'd5;
	localparam logic [4:0] S_BINIT  = 5'd6;
	localparam logic [4:0] S_BPRD   = 5'd7;
	localparam logic [4:0] S_BPCHK  = 5'd8;
	localparam logic [4:0] S_BMARK  = 5'd9;
	localparam logic [4:0] S_BLDIV  = 5'd10;
	localparam logic [4:0] S_BSEG   = 5'd11;
	localparam logic [4:0] S_BSRD   = 5'd12;
	localparam logic [4:0] S_BSTART = 5'd13;
	localparam logic [4:0] S_BDIV   = 5'd14;
	localparam logic [4:0] S_BREDIV = 5'd15;
	localparam logic [4:0] S_BSWR   = 5'd16;
	localparam logic [4:0] S_BFRD   = 5'd17;
	localparam logic [4:0] S_BFWR   = 5'd18;
	localparam logic [4:0] S_QCHK   = 5'd19;
	localparam logic [4:0] S_QMAP   = 5'd20;
	localparam logic [4:0] S_QRD    = 5'd21;
	localparam logic [4:0] S_QSEL   = 5'd22;
	localparam logic [4:0] S_QWORD  = 5'd23;
	localparam logic [4:0] S_QWAIT  = 5'd24;
	localparam logic [4:0] S_QBIG   = 5'd25;

	logic [4:0]        state_q, state_d;
	logic [OSEL_W-1:0] sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= OS_ZERO;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	// next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		sel_d    = sel_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (in_command == CMD_BUILD) begin
						cmd.clr_built = 1'b1;
						state_d       = S_BCHK;
					end else begin
						state_d = S_QCHK;
					end
				end
			end
			S_OUT: begin
				if (sts.slot_free) begin
					cmd.emit    = 1'b1;
					cmd.out_sel = sel_q;
					state_d     = S_IDLE;
				end
			end
			// build: segment checks and root
			S_BCHK: begin
				if (sts.seg_bad) begin
					sel_d   = OS_BAD;
					state_d = S_OUT;
				end else begin
					cmd.sq_start = 1'b1;
					state_d      = S_BSQ;
				end
			end
			S_BSQ: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_last)
					state_d = S_BSQCHK;
			end
			S_BSQCHK: begin
				if (sts.root_big) begin
					sel_d   = OS_BAD;
					state_d = S_OUT;
				end else begin
					cmd.clr_init = 1'b1;
					state_d      = S_BCLR;
				end
			end
			// clear map and load residues
			S_BCLR: begin
				if (sts.j_gt_m) begin
					cmd.init_start = 1'b1;
					state_d        = S_BINIT;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			S_BINIT: begin
				if (sts.i_ge_span) begin
					cmd.p_init = 1'b1;
					state_d    = S_BPRD;
				end else begin
					cmd.init_step = 1'b1;
				end
			end
			// prime loop
			S_BPRD: begin
				if (sts.p_gt_m) begin
					cmd.fin_init = 1'b1;
					state_d      = S_BFRD;
				end else begin
					state_d = S_BPCHK;
				end
			end
			S_BPCHK: begin
				if (sts.map_bit) begin
					cmd.p_inc = 1'b1;
					state_d   = S_BPRD;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_BMARK;
				end
			end
			S_BMARK: begin
				if (sts.j_gt_m) begin
					cmd.ldiv_start = 1'b1;
					state_d        = S_BLDIV;
				end else begin
					cmd.mark_step = 1'b1;
				end
			end
			S_BLDIV: begin
				if (!sts.div_busy) begin
					cmd.off_load = 1'b1;
					state_d      = S_BSEG;
				end
			end
			// walk the multiples in the segment
			S_BSEG: begin
				if (sts.i_ge_span) begin
					cmd.p_inc = 1'b1;
					state_d   = S_BPRD;
				end else begin
					state_d = S_BSRD;
				end
			end
			S_BSRD: begin
				cmd.seg_cap = 1'b1;
				state_d     = S_BSTART;
			end
			S_BSTART: begin
				if (sts.res_zero) begin
					cmd.seg_skip = 1'b1;
					state_d      = S_BSEG;
				end else begin
					cmd.rdiv_start = 1'b1;
					state_d        = S_BDIV;
				end
			end
			S_BDIV: begin
				if (!sts.div_busy) begin
					if (sts.rem_zero) begin
						cmd.div_take = 1'b1;
						state_d      = S_BREDIV;
					end else begin
						state_d = S_BSWR;
					end
				end
			end
			S_BREDIV: begin
				cmd.rdiv_start = 1'b1;
				state_d        = S_BDIV;
			end
			S_BSWR: begin
				cmd.seg_wr = 1'b1;
				state_d    = S_BSEG;
			end
			// large cofactors
			S_BFRD: begin
				if (sts.i_ge_span) begin
					cmd.set_built = 1'b1;
					sel_d         = OS_ZERO;
					state_d       = S_OUT;
				end else begin
					state_d = S_BFWR;
				end
			end
			S_BFWR: begin
				cmd.fin_wr = 1'b1;
				state_d    = S_BFRD;
			end
			// query
			S_QCHK: begin
				if (!sts.built) begin
					sel_d   = OS_ST1;
					state_d = S_OUT;
				end else if (sts.v_le1) begin
					sel_d   = OS_ZERO;
					state_d = S_OUT;
				end else if (sts.v_in_seg) begin
					state_d = S_QRD;
				end else if (sts.v_in_small) begin
					state_d = S_QMAP;
				end else begin
					sel_d   = OS_ST1;
					state_d = S_OUT;
				end
			end
			S_QMAP: begin
				sel_d   = OS_MAP;
				state_d = S_OUT;
			end
			S_QRD: begin
				cmd.q_cap = 1'b1;
				state_d   = S_QSEL;
			end
			S_QSEL: begin
				if (sts.total_zero) begin
					sel_d   = OS_ZERO;
					state_d = S_OUT;
				end else if (sts.n_zero) begin
					state_d = S_QBIG;
				end else begin
					state_d = S_QWORD;
				end
			end
			S_QWORD: begin
				if (sts.slot_free) begin
					cmd.emit    = 1'b1;
					cmd.out_sel = OS_WORD;
					if (!sts.k_last) begin
						cmd.k_inc = 1'b1;
						state_d   = S_QWAIT;
					end else if (sts.has_big) begin
						state_d = S_QBIG;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_QWAIT: state_d = S_QWORD;
			S_QBIG: begin
				if (sts.slot_free) begin
					cmd.emit    = 1'b1;
					cmd.out_sel = OS_BIG;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
